// ----- hw/rtl/abte_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abte_pkg
// shared types, codes and helpers for the array binary tree engine
// ----------------------------------------------------------------------------
package abte_pkg;

    localparam int SLOT_COUNT = 63;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int LVL_W      = $clog2(SLOT_W + 1);

    localparam logic signed [31:0] EMPTY_SLOT = 32'hFFFF_FFFF;

    // action codes
    localparam logic [2:0] ACT_CLEAR   = 3'd0;
    localparam logic [2:0] ACT_INSERT  = 3'd1;
    localparam logic [2:0] ACT_DELETE  = 3'd2;
    localparam logic [2:0] ACT_HEIGHT  = 3'd3;
    localparam logic [2:0] ACT_MIN     = 3'd4;
    localparam logic [2:0] ACT_LEVEL   = 3'd5;
    localparam logic [2:0] ACT_INORDER = 3'd6;
    localparam logic [2:0] ACT_NONE    = 3'd7;

    // insert side codes
    localparam logic [1:0] SIDE_LEFT  = 2'd0;
    localparam logic [1:0] SIDE_RIGHT = 2'd1;
    localparam logic [1:0] SIDE_SELF  = 2'd2;
    localparam logic [1:0] SIDE_BAD   = 2'd3;

    // config register indexes
    localparam logic CFG_EMPTY_MIN = 1'b0;
    localparam logic CFG_SKIP      = 1'b1;

    typedef struct packed {
        logic [2:0]         action;
        logic [5:0]         node_index;
        logic [1:0]         side;
        logic signed [31:0] item_value;
    } item_t;

    typedef struct packed {
        logic signed [31:0] answer;
        logic               hit;
    } result_t;

    typedef struct packed {
        logic load;
        logic start;
        logic sweep;
        logic go_left;
        logic go_right;
        logic go_up;
        logic visit;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic       root_go;
        logic       sweep_last;
        logic       left_mk;
        logic       right_mk;
        logic       at_root;
        logic       cur_odd;
        logic       match_now;
    } stat_t;

    // tree level of a slot: floor(log2(x + 1))
    function automatic logic [LVL_W-1:0] lvl_of(input logic [SLOT_W-1:0] x);
        logic [SLOT_W:0]   y;
        logic [LVL_W-1:0]  r;
        y = {1'b0, x} + {{SLOT_W{1'b0}}, 1'b1};
        r = '0;
        for (int b = 0; b <= SLOT_W; b++)
        begin
            if (y[b])
            begin
                r = LVL_W'(b);
            end
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/array_binary_tree_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_binary_tree_engine
// heap-indexed binary tree of 63 signed slots with insert, delete, search and query actions
// ----------------------------------------------------------------------------
// One item is worked at a time and gives one result beat. Clear, insert and
// any action whose root check fails go from the start state straight to the
// finish state. Delete, height, minimum and level-order search sweep the
// slots in index order from the subtree root to the last slot, one slot per
// cycle through the single read port of the slot store, then drain the last
// read. In-order search walks the occupied subtree one step per cycle and
// reads each node in a visit state and checks it in a following check
// state. Occupancy lives in flip-flops cleared by reset and by clear, so no
// clearing pass is needed. A new item is taken as soon as the sequencer is
// idle, even while the previous result beat is still stalled.
// Configuration writes are always ready.
// ----------------------------------------------------------------------------
module array_binary_tree_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  abte_pkg::item_t     item,
    output logic                result_valid,
    input  logic                result_stall,
    output abte_pkg::result_t   result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);
    import abte_pkg::*;

    cmd_t  cmd;
    stat_t st;

    // registers may be written at any time the port is idle
    assign cfg_ready = 1'b1;

    // sequencer: owns the state machine and the result beat valid
    abte_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .st           (st)
    );

    // datapath: slot store, occupancy, marks, cursor and result register
    abte_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .item      (item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (result)
    );

    // an accepted beat keeps the engine busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("engine not busy after accept");

    // a pending stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(result_valid && result_stall))
        else $error("result overwritten while stalled");

    // the slot store is only read while an item is being worked
    a_read_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sweep || cmd.visit) |-> item_stall)
        else $error("slot read while idle");

endmodule

// ----- hw/rtl/abte_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abte_datapath
// slot memory, occupancy and mark bits, cursor, accumulator and result beat
// ----------------------------------------------------------------------------
module abte_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  abte_pkg::cmd_t  cmd,
    output abte_pkg::stat_t st,
    input  abte_pkg::item_t item,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [31:0]     cfg_data,
    output abte_pkg::result_t res
);
    import abte_pkg::*;

    logic [2:0]              act_reg;
    logic [5:0]              node_reg;
    logic [1:0]              side_reg;
    logic signed [31:0]      val_reg;
    logic signed [31:0]      emin_reg;
    logic signed [31:0]      skip_reg;
    logic [SLOT_COUNT-1:0]   occ_reg;
    logic [SLOT_COUNT-1:0]   mk_reg;
    logic [SLOT_W-1:0]       cur_reg;
    logic signed [31:0]      acc_reg;
    logic                    hit_reg;
    logic signed [31:0]      mem [SLOT_COUNT];
    logic signed [31:0]      rdata_reg;
    logic                    rd_vld_reg;
    logic                    rd_mark_reg;
    logic [SLOT_W-1:0]       rd_idx_reg;
    result_t                 res_reg;

    logic [31:0]       node32, par32, tgt32, cur32, left32, right32, pc32;
    logic [SLOT_W-1:0] node_s, par_c;
    logic              node_in, root_occ, min_ok, neg_val, root_go;
    logic              par_ok, ins_ok, need_right, mark_i, left_mk, right_mk;
    logic              rd_en, rd_mark, match_now;
    logic [LVL_W-1:0]  diff;

    assign node32   = 32'(node_reg);
    assign node_s   = SLOT_W'(node_reg);
    assign node_in  = node32 < 32'(SLOT_COUNT);
    assign root_occ = node_in && occ_reg[node_s];
    assign min_ok   = root_occ && ((node32 << 1) + 32'd1 < 32'(SLOT_COUNT));
    assign neg_val  = val_reg == EMPTY_SLOT;

    always_comb
    begin
        case (act_reg) inside
            ACT_DELETE, ACT_HEIGHT, ACT_LEVEL: root_go = root_occ;
            ACT_MIN:                           root_go = min_ok;
            ACT_INORDER:                       root_go = root_occ && !neg_val;
            default:                           root_go = 1'b0;
        endcase
    end

    // insert checks
    assign par32  = (node32 - 32'd1) >> 1;
    assign par_ok = (node_reg == '0) ||
                    (par32 < 32'(SLOT_COUNT) && occ_reg[par32[SLOT_W-1:0]]);
    always_comb
    begin
        case (side_reg)
            SIDE_LEFT:  tgt32 = (node32 << 1) + 32'd1;
            SIDE_RIGHT: tgt32 = (node32 << 1) + 32'd2;
            default:    tgt32 = node32;
        endcase
    end
    assign ins_ok = par_ok && (side_reg == SIDE_LEFT || side_reg == SIDE_RIGHT ||
                    side_reg == SIDE_SELF) && tgt32 < 32'(SLOT_COUNT) &&
                    !occ_reg[tgt32[SLOT_W-1:0]];

    // index-order sweep marking
    assign cur32      = 32'(cur_reg);
    assign par_c      = (cur_reg - SLOT_W'(1)) >> 1;
    assign pc32       = 32'(par_c);
    assign need_right = (act_reg == ACT_HEIGHT) || (act_reg == ACT_MIN);
    assign mark_i     = (cur_reg == node_s) ? mk_reg[node_s] :
                        (mk_reg[par_c] && occ_reg[cur_reg] &&
                         (!need_right || ((pc32 << 1) + 32'd2 < 32'(SLOT_COUNT))));
    assign diff       = lvl_of(cur_reg) - lvl_of(node_s);

    // in-order walk neighbors
    assign left32   = (cur32 << 1) + 32'd1;
    assign right32  = (cur32 << 1) + 32'd2;
    assign left_mk  = left32 < 32'(SLOT_COUNT) && occ_reg[left32[SLOT_W-1:0]];
    assign right_mk = right32 < 32'(SLOT_COUNT) && occ_reg[right32[SLOT_W-1:0]];

    assign rd_en     = cmd.sweep || cmd.visit;
    assign rd_mark   = cmd.visit ? 1'b1 : mark_i;
    assign match_now = rd_vld_reg && rd_mark_reg && (rdata_reg == val_reg);

    always_comb
    begin
        st.action     = act_reg;
        st.root_go    = root_go;
        st.sweep_last = cur_reg == SLOT_W'(SLOT_COUNT - 1);
        st.left_mk    = left_mk;
        st.right_mk   = right_mk;
        st.at_root    = cur_reg == node_s;
        st.cur_odd    = cur_reg[0];
        st.match_now  = match_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= '0;
            mk_reg     <= '0;
            rd_vld_reg <= 1'b0;
            emin_reg   <= 32'sd0;
            skip_reg   <= 32'sh7FFF_FFFF;
        end
        else
        begin
            rd_vld_reg <= rd_en;
            if (cfg_we)
            begin
                if (cfg_index == CFG_EMPTY_MIN)
                begin
                    emin_reg <= cfg_data;
                end
                else
                begin
                    skip_reg <= cfg_data;
                end
            end
            if (cmd.start)
            begin
                mk_reg <= '0;
                if (node_in)
                begin
                    mk_reg[node_s] <= root_go;
                end
                if (act_reg == ACT_CLEAR)
                begin
                    occ_reg <= '0;
                end
                else if (act_reg == ACT_INSERT && ins_ok)
                begin
                    occ_reg[tgt32[SLOT_W-1:0]] <= !neg_val;
                end
            end
            if (cmd.sweep)
            begin
                mk_reg[cur_reg] <= mark_i;
                if (act_reg == ACT_DELETE && mark_i)
                begin
                    occ_reg[cur_reg] <= 1'b0;
                end
            end
        end
    end

    // slot store: written by insert, read at most once a cycle, while sweeping or visiting
    always_ff @(posedge clk)
    begin
        if (cmd.start && act_reg == ACT_INSERT && ins_ok)
        begin
            mem[tgt32[SLOT_W-1:0]] <= val_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[cur_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= item.action;
            node_reg <= item.node_index;
            side_reg <= item.side;
            val_reg  <= item.item_value;
        end
        if (rd_en)
        begin
            rd_mark_reg <= rd_mark;
            rd_idx_reg  <= cur_reg;
        end

        if (cmd.start)
        begin
            cur_reg <= node_s;
        end
        else if (cmd.sweep)
        begin
            cur_reg <= cur_reg + SLOT_W'(1);
        end
        else if (cmd.go_left)
        begin
            cur_reg <= left32[SLOT_W-1:0];
        end
        else if (cmd.go_right)
        begin
            cur_reg <= right32[SLOT_W-1:0];
        end
        else if (cmd.go_up)
        begin
            cur_reg <= par_c;
        end

        if (cmd.start)
        begin
            acc_reg <= 32'sd0;
            hit_reg <= 1'b0;
            case (act_reg)
                ACT_INSERT: hit_reg <= ins_ok && !neg_val;
                ACT_DELETE: hit_reg <= root_occ;
                ACT_MIN:    acc_reg <= min_ok ? skip_reg : emin_reg;
                ACT_LEVEL:  acc_reg <= EMPTY_SLOT;
                ACT_INORDER:
                begin
                    if (node_in && !root_occ && neg_val)
                    begin
                        acc_reg <= node32;
                        hit_reg <= 1'b1;
                    end
                    else
                    begin
                        acc_reg <= EMPTY_SLOT;
                    end
                end
                default: ;
            endcase
        end
        else if (cmd.sweep && act_reg == ACT_HEIGHT && mark_i)
        begin
            if (32'(diff) > acc_reg)
            begin
                acc_reg <= 32'(diff);
            end
        end
        else if (rd_vld_reg)
        begin
            if (act_reg == ACT_MIN)
            begin
                if (rd_mark_reg && rdata_reg < acc_reg)
                begin
                    acc_reg <= rdata_reg;
                end
            end
            else if ((act_reg == ACT_LEVEL || act_reg == ACT_INORDER) &&
                     match_now && !hit_reg)
            begin
                acc_reg <= 32'(rd_idx_reg);
                hit_reg <= 1'b1;
            end
        end

        if (cmd.finish)
        begin
            res_reg.answer <= acc_reg;
            res_reg.hit    <= hit_reg;
        end
    end

    assign res = res_reg;

endmodule

// ----- hw/rtl/abte_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abte_ctrl
// sequencer for the tree engine and result beat handshake
// ----------------------------------------------------------------------------
module abte_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    output logic            result_valid,
    input  logic            result_stall,
    output abte_pkg::cmd_t  cmd,
    input  abte_pkg::stat_t st
);
    import abte_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_START = 9'b000000010,
        S_SWEEP = 9'b000000100,
        S_DRAIN = 9'b000001000,
        S_DESC  = 9'b000010000,
        S_VISIT = 9'b000100000,
        S_CHECK = 9'b001000000,
        S_CLIMB = 9'b010000000,
        S_FIN   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;

    assign item_stall   = state_reg != S_IDLE;
    assign result_valid = ovalid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.start = 1'b1;
                case (st.action) inside
                    ACT_DELETE, ACT_HEIGHT, ACT_MIN, ACT_LEVEL:
                        state_next = st.root_go ? S_SWEEP : S_FIN;
                    ACT_INORDER:
                        state_next = st.root_go ? S_DESC : S_FIN;
                    default:
                        state_next = S_FIN;
                endcase
            end
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (st.sweep_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: state_next = S_FIN;
            S_DESC:
            begin
                if (st.left_mk)
                begin
                    cmd.go_left = 1'b1;
                end
                else
                begin
                    state_next = S_VISIT;
                end
            end
            S_VISIT:
            begin
                cmd.visit  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (st.match_now)
                begin
                    state_next = S_FIN;
                end
                else if (st.right_mk)
                begin
                    cmd.go_right = 1'b1;
                    state_next   = S_DESC;
                end
                else
                begin
                    state_next = S_CLIMB;
                end
            end
            S_CLIMB:
            begin
                if (st.at_root)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.go_up = 1'b1;
                    if (st.cur_odd)
                    begin
                        state_next = S_VISIT;
                    end
                end
            end
            S_FIN:
            begin
                if (!ovalid_reg || !result_stall)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (ovalid_reg && !result_stall)
        begin
            ovalid_next = 1'b0;
        end
        if (cmd.finish)
        begin
            ovalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule
